// ----- design/hlw_pkg.sv -----
// Shared types, codes and constants of the helical lattice walker.
`default_nettype none
package hlw_pkg;

    localparam int EDGE_X_DEF     = 32;
    localparam int EDGE_Y_DEF     = 32;
    localparam int EDGE_Z_DEF     = 32;
    localparam int RADIUS_MAX_DEF = 16;
    localparam int CENTRE_DEF     = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int A_W     = 9;
    localparam int C_W     = 24;
    localparam int E_W     = 48;
    localparam int COORD_W = 11;
    localparam int OFF_W   = 10;
    localparam int OSQ_W   = 20;
    localparam int DDA_W   = 12;
    localparam int ACC_W   = 11;
    localparam int STEP_W  = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_X = 3'd0,
        REG_AXIS_Y = 3'd1,
        REG_AXIS_Z = 3'd2,
        REG_ORBIT  = 3'd3,
        REG_PERP_X = 3'd4,
        REG_PERP_Y = 3'd5,
        REG_PERP_Z = 3'd6
    } hlw_reg_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } hlw_cmd_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_SHELL = 2'd1,
        ST_LIMIT = 2'd2,
        ST_IDLE  = 2'd3
    } hlw_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CROSS,
        S_ENERGY,
        S_GAIN,
        S_CLIMB,
        S_NBR,
        S_SELECT,
        S_DECIDE,
        S_APPLY,
        S_GUPD,
        S_MARK_RD,
        S_MARK_WR,
        S_FIN,
        S_OUT
    } hlw_state_t;

    typedef struct packed {
        logic [2:0][A_W-1:0]      a;
        logic [2:0][A_W-1:0]      absa;
        logic [9:0]               climb;
        logic [7:0]               orbit;
        logic [5:0][2:0][A_W-1:0] d;
        logic [E_W-1:0]           tgt;
        logic [E_W-1:0]           tol;
        logic [2:0][A_W-1:0]      u;
    } hlw_derive_t;

endpackage
`default_nettype wire

// ----- design/hlw_if.sv -----
// Request and result channel interfaces of the helical lattice walker.
`default_nettype none
interface hlw_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] tick;

    modport source (output valid, output command, output tick, input ready);
    modport sink (input valid, input command, input tick, output ready);
endinterface

interface hlw_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [4:0]  cell_z;
    logic [31:0] stamp;
    logic        stamped;
    logic [1:0]  walk_status;

    modport source (output valid, output cell_x, output cell_y, output cell_z,
                    output stamp, output stamped, output walk_status, input ready);
    modport sink (input valid, input cell_x, input cell_y, input cell_z,
                  input stamp, input stamped, input walk_status, output ready);
endinterface
`default_nettype wire

// ----- design/hlw_vmap.sv -----
// Visited map memory: one row of z bits per (x, y) column, registered read.
`default_nettype none
module hlw_vmap #(
    parameter int ROWS  = 1024,
    parameter int ROW_W = 32,
    parameter int RA_W  = 10
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [RA_W-1:0]  waddr,
    input  wire logic [ROW_W-1:0] wdata,
    input  wire logic [RA_W-1:0]  raddr,
    output logic      [ROW_W-1:0] rdata
);
    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ----- design/hlw_cfg.sv -----
// Configuration registers and the axis constants derived from them.
`default_nettype none
module hlw_cfg #(
    parameter int RADIUS_MAX = hlw_pkg::RADIUS_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [hlw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hlw_pkg::CFG_DATA_W-1:0] cfg_data,
    output hlw_pkg::hlw_derive_t                dv
);
    import hlw_pkg::*;

    localparam int RC    = (RADIUS_MAX * 93 + 256) / 512;
    localparam int RC_SQ = RC * RC;
    localparam int RC_TL = 2 * RC + 1;

    logic [5:0] axis_x_reg, axis_y_reg, axis_z_reg;
    logic [5:0] perp_x_reg, perp_y_reg, perp_z_reg;
    logic [7:0] orbit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg <= 6'd0;
            axis_y_reg <= 6'd0;
            axis_z_reg <= 6'd16;
            orbit_reg  <= 8'd24;
            perp_x_reg <= 6'd0;
            perp_y_reg <= 6'd0;
            perp_z_reg <= 6'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AXIS_X: axis_x_reg <= cfg_data[5:0];
                REG_AXIS_Y: axis_y_reg <= cfg_data[5:0];
                REG_AXIS_Z: axis_z_reg <= cfg_data[5:0];
                REG_ORBIT:  orbit_reg  <= cfg_data;
                REG_PERP_X: perp_x_reg <= cfg_data[5:0];
                REG_PERP_Y: perp_y_reg <= cfg_data[5:0];
                REG_PERP_Z: perp_z_reg <= cfg_data[5:0];
                default:    ;
            endcase
        end
    end

    logic signed [A_W-1:0] ax, ay, az, px, py, pz;
    logic signed [A_W-1:0] av [3];
    logic [15:0]           a2;

    always_comb
    begin
        ax = A_W'(signed'(axis_x_reg));
        ay = A_W'(signed'(axis_y_reg));
        az = A_W'(signed'(axis_z_reg));
        px = A_W'(signed'(perp_x_reg));
        py = A_W'(signed'(perp_y_reg));
        pz = A_W'(signed'(perp_z_reg));
        if (ax == 0 && ay == 0 && az == 0)
        begin
            az = A_W'(RADIUS_MAX);
        end
        av[0] = ax;
        av[1] = ay;
        av[2] = az;
        a2 = 16'(ax * ax) + 16'(ay * ay) + 16'(az * az);

        for (int i = 0; i < 3; i++)
        begin
            dv.a[i]    = av[i];
            dv.absa[i] = (av[i] < 0) ? A_W'(-av[i]) : av[i];
        end
        dv.climb = 10'(dv.absa[0]) + 10'(dv.absa[1]) + 10'(dv.absa[2]);
        dv.orbit = orbit_reg;

        dv.d[0][0] = '0;              dv.d[0][1] = A_W'(-az);  dv.d[0][2] = ay;
        dv.d[1][0] = '0;              dv.d[1][1] = az;         dv.d[1][2] = A_W'(-ay);
        dv.d[2][0] = az;              dv.d[2][1] = '0;         dv.d[2][2] = A_W'(-ax);
        dv.d[3][0] = A_W'(-az);       dv.d[3][1] = '0;         dv.d[3][2] = ax;
        dv.d[4][0] = A_W'(-ay);       dv.d[4][1] = ax;         dv.d[4][2] = '0;
        dv.d[5][0] = ay;              dv.d[5][1] = A_W'(-ax);  dv.d[5][2] = '0;

        dv.tgt = E_W'(RC_SQ * int'(a2));
        dv.tol = E_W'(RC_TL * int'(a2));

        dv.u[0] = A_W'(-px);
        dv.u[1] = A_W'(-py);
        dv.u[2] = A_W'(-pz);
    end
endmodule
`default_nettype wire

// ----- design/helical_lattice_walker_top.sv -----
// Top level of the helical lattice walker: sequencer, walk state and result register.
`default_nettype none
// The block takes one request at a time. A start request clears the visited
// map one row per cycle before its result is made ready; a step request
// passes through the six visited-map reads of the neighbor cells, the sweep
// over the six candidate moves and the six gain updates that share one
// dot-product unit. A step on an idle or finished walk goes straight to the
// output register. A finished result waits in the output register while the
// next request is taken. Configuration is written through cfg_we, cfg_index and
// cfg_data, with cfg_index following the register list from axis_x (0) to
// perp_z (6); other indexes are ignored.
module helical_lattice_walker_top #(
    parameter int EDGE_X     = hlw_pkg::EDGE_X_DEF,
    parameter int EDGE_Y     = hlw_pkg::EDGE_Y_DEF,
    parameter int EDGE_Z     = hlw_pkg::EDGE_Z_DEF,
    parameter int RADIUS_MAX = hlw_pkg::RADIUS_MAX_DEF,
    parameter int CENTRE     = hlw_pkg::CENTRE_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    hlw_cmd_if.sink                             cmd,
    hlw_res_if.source                           res,
    input  wire logic                           cfg_we,
    input  wire logic [hlw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hlw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hlw_pkg::*;

    localparam int NROWS      = EDGE_X * EDGE_Y;
    localparam int RA_W       = $clog2(NROWS);
    localparam int ZW         = $clog2(EDGE_Z);
    localparam int RAD2       = (RADIUS_MAX - 2) * (RADIUS_MAX - 2);
    localparam int STEP_LIMIT = 12 * RADIUS_MAX;

    hlw_derive_t dv;

    hlw_cfg #(.RADIUS_MAX(RADIUS_MAX)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dv        (dv)
    );

    logic              mem_we;
    logic [RA_W-1:0]   mem_waddr, mem_raddr;
    logic [EDGE_Z-1:0] mem_wdata, mem_rdata;

    hlw_vmap #(.ROWS(NROWS), .ROW_W(EDGE_Z), .RA_W(RA_W)) u_vmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hlw_state_t state_reg, state_next;

    logic                      cmd_reg;
    logic [31:0]               tick_reg;
    logic signed [COORD_W-1:0] tip_reg [3];
    logic signed [OFF_W-1:0]   off_reg [3];
    logic signed [OSQ_W-1:0]   offsq_reg;
    logic signed [C_W-1:0]     cross_reg [3];
    logic signed [E_W-1:0]     energy_reg;
    logic signed [E_W-1:0]     gain_reg [6];
    logic [ACC_W-1:0]          acc_reg;
    logic signed [DDA_W-1:0]   dda_reg [3];
    logic [STEP_W-1:0]         step_reg;
    logic                      live_reg;
    logic [RA_W-1:0]           cnt_reg;
    logic [2:0]                idx_reg;
    logic [5:0]                ok_reg;
    logic [ZW-1:0]             pend_z_reg;
    logic                      pend_in_reg;
    logic                      climb_hit_reg;
    logic [2:0]                climb_m_reg;
    logic                      b1v_reg, b2v_reg;
    logic [2:0]                b1m_reg, b2m_reg, chosen_reg;
    logic signed [E_W-1:0]     b1err_reg, b2err_reg;
    logic signed [C_W-1:0]     b1tan_reg;
    logic                      res_stamped_reg;
    hlw_status_t               res_status_reg;

    logic        out_valid_reg;
    logic [4:0]  out_x_reg, out_y_reg, out_z_reg;
    logic [31:0] out_stamp_reg;
    logic        out_stamped_reg;
    logic [1:0]  out_status_reg;

    function automatic logic in_lat(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y,
                                    input logic signed [COORD_W-1:0] z);
        in_lat = (x >= 0) && (x < signed'(COORD_W'(EDGE_X)))
              && (y >= 0) && (y < signed'(COORD_W'(EDGE_Y)))
              && (z >= 0) && (z < signed'(COORD_W'(EDGE_Z)));
    endfunction

    function automatic logic [RA_W-1:0] row_of(input logic signed [COORD_W-1:0] x,
                                               input logic signed [COORD_W-1:0] y);
        row_of = RA_W'(int'(x) * EDGE_Y + int'(y));
    endfunction

    // Neighbor of the tip for move idx_reg.
    logic signed [COORD_W-1:0] nb [3];
    logic                      nb_in, tip_in;
    logic [RA_W-1:0]           nb_row, tip_row;
    logic [ZW-1:0]             tip_z;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            nb[c] = tip_reg[c];
            if (idx_reg[2:1] == 2'(c))
            begin
                nb[c] = idx_reg[0] ? COORD_W'(tip_reg[c] - COORD_W'(1))
                                   : COORD_W'(tip_reg[c] + COORD_W'(1));
            end
        end
        nb_in   = in_lat(nb[0], nb[1], nb[2]);
        nb_row  = row_of(nb[0], nb[1]);
        tip_in  = in_lat(tip_reg[0], tip_reg[1], tip_reg[2]);
        tip_row = row_of(tip_reg[0], tip_reg[1]);
        tip_z   = ZW'(tip_reg[2]);
    end

    always_comb
    begin
        mem_we    = (state_reg == S_CLEAR) || (state_reg == S_MARK_WR);
        mem_waddr = (state_reg == S_CLEAR) ? cnt_reg : tip_row;
        mem_wdata = (state_reg == S_CLEAR) ? '0 : (mem_rdata | (EDGE_Z'(1) << tip_z));
        mem_raddr = (state_reg == S_NBR) ? nb_row : tip_row;
    end

    // Direction vectors of the chosen move and of the move under idx_reg.
    logic signed [A_W-1:0] dsel [3];
    logic signed [A_W-1:0] didx [3];
    logic signed [E_W-1:0] dot_sel_idx, dot_cross_idx, dot_idx_idx, cross_sq;
    logic signed [E_W-1:0] tgt_s, tol_s;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dsel[c] = $signed(dv.d[chosen_reg][c]);
            didx[c] = $signed(dv.d[idx_reg][c]);
        end
        dot_sel_idx   = E_W'(dsel[0] * didx[0]) + E_W'(dsel[1] * didx[1])
                      + E_W'(dsel[2] * didx[2]);
        dot_idx_idx   = E_W'(didx[0] * didx[0]) + E_W'(didx[1] * didx[1])
                      + E_W'(didx[2] * didx[2]);
        dot_cross_idx = E_W'(E_W'(cross_reg[0]) * E_W'(didx[0]))
                      + E_W'(E_W'(cross_reg[1]) * E_W'(didx[1]))
                      + E_W'(E_W'(cross_reg[2]) * E_W'(didx[2]));
        cross_sq      = E_W'(E_W'(cross_reg[idx_reg[1:0]]) * E_W'(cross_reg[idx_reg[1:0]]));
        tgt_s         = $signed(dv.tgt);
        tol_s         = $signed(dv.tol);
    end

    // Candidate evaluation for the sweep.
    logic signed [E_W-1:0] sel_sum, sel_e;
    logic signed [C_W-1:0] sel_t;

    always_comb
    begin
        sel_sum = E_W'(energy_reg + gain_reg[idx_reg] - tgt_s);
        sel_e   = (sel_sum < 0) ? E_W'(-sel_sum) : sel_sum;
        sel_t   = idx_reg[0] ? cross_reg[idx_reg[2:1]] : C_W'(-cross_reg[idx_reg[2:1]]);
    end

    // Climb accumulator and axis DDA.
    logic [ACC_W-1:0]        period, acc_sum;
    logic signed [DDA_W-1:0] dda_new [3];
    logic [1:0]              climb_i;

    always_comb
    begin
        period  = ACC_W'(dv.orbit) + ACC_W'(dv.climb);
        acc_sum = acc_reg + ACC_W'(dv.climb);
        for (int c = 0; c < 3; c++)
        begin
            dda_new[c] = DDA_W'(dda_reg[c] + signed'(DDA_W'(dv.absa[c])));
        end
        climb_i = 2'd0;
        if (dda_new[1] > dda_new[0])
        begin
            climb_i = 2'd1;
        end
        if (dda_new[2] > dda_new[climb_i])
        begin
            climb_i = 2'd2;
        end
    end

    logic climb_ok, boxed, out_load;
    logic [STEP_W-1:0] step_inc;

    always_comb
    begin
        climb_ok = climb_hit_reg && ok_reg[climb_m_reg];
        boxed    = !climb_ok && !b1v_reg && !b2v_reg;
        out_load = (state_reg == S_OUT) && (!out_valid_reg || res.ready);
        step_inc = step_reg + STEP_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.command == CMD_START)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (live_reg)
                    begin
                        state_next = S_CLIMB;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_CLEAR:   if (cnt_reg == RA_W'(NROWS - 1)) state_next = S_CROSS;
            S_CROSS:   state_next = S_ENERGY;
            S_ENERGY:  if (idx_reg == 3'd2) state_next = S_GAIN;
            S_GAIN:    if (idx_reg == 3'd5) state_next = S_MARK_RD;
            S_CLIMB:   state_next = S_NBR;
            S_NBR:     if (idx_reg == 3'd6) state_next = S_SELECT;
            S_SELECT:  if (idx_reg == 3'd5) state_next = S_DECIDE;
            S_DECIDE:  state_next = boxed ? S_OUT : S_APPLY;
            S_APPLY:   state_next = S_GUPD;
            S_GUPD:    if (idx_reg == 3'd5) state_next = S_MARK_RD;
            S_MARK_RD: state_next = tip_in ? S_MARK_WR : S_FIN;
            S_MARK_WR: state_next = S_FIN;
            S_FIN:     state_next = S_OUT;
            S_OUT:     if (out_load) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            cnt_reg  <= '0;
            live_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                tip_reg[c]   <= COORD_W'(CENTRE);
                off_reg[c]   <= '0;
                cross_reg[c] <= '0;
                dda_reg[c]   <= '0;
            end
            for (int m = 0; m < 6; m++)
            begin
                gain_reg[m] <= '0;
            end
            offsq_reg  <= '0;
            energy_reg <= '0;
            acc_reg    <= '0;
            step_reg   <= '0;
        end
        else
        begin
            idx_reg <= (state_next != state_reg) ? 3'd0 : 3'(idx_reg + 3'd1);
            cnt_reg <= (state_reg == S_CLEAR) ? RA_W'(cnt_reg + RA_W'(1)) : '0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        cmd_reg         <= cmd.command;
                        tick_reg        <= cmd.tick;
                        res_stamped_reg <= 1'b0;
                        res_status_reg  <= ST_IDLE;
                    end
                end
                S_CROSS:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        tip_reg[c] <= COORD_W'(CENTRE);
                        off_reg[c] <= '0;
                        dda_reg[c] <= '0;
                    end
                    cross_reg[0] <= C_W'($signed(dv.u[1]) * $signed(dv.a[2])
                                       - $signed(dv.u[2]) * $signed(dv.a[1]));
                    cross_reg[1] <= C_W'($signed(dv.u[2]) * $signed(dv.a[0])
                                       - $signed(dv.u[0]) * $signed(dv.a[2]));
                    cross_reg[2] <= C_W'($signed(dv.u[0]) * $signed(dv.a[1])
                                       - $signed(dv.u[1]) * $signed(dv.a[0]));
                    offsq_reg  <= '0;
                    energy_reg <= '0;
                    acc_reg    <= '0;
                    step_reg   <= '0;
                    live_reg   <= 1'b1;
                end
                S_ENERGY:
                begin
                    energy_reg <= E_W'(energy_reg + cross_sq);
                end
                S_GAIN:
                begin
                    gain_reg[idx_reg] <= E_W'(2 * dot_cross_idx + dot_idx_idx);
                end
                S_CLIMB:
                begin
                    climb_hit_reg <= (acc_sum >= period);
                    if (acc_sum >= period)
                    begin
                        acc_reg <= ACC_W'(acc_sum - period);
                        for (int c = 0; c < 3; c++)
                        begin
                            dda_reg[c] <= (climb_i == 2'(c))
                                ? DDA_W'(dda_new[c] - signed'(DDA_W'(dv.climb)))
                                : dda_new[c];
                        end
                        climb_m_reg <= {climb_i, $signed(dv.a[climb_i]) < 0};
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                    end
                end
                S_NBR:
                begin
                    if (idx_reg != 3'd0)
                    begin
                        ok_reg[3'(idx_reg - 3'd1)] <= pend_in_reg && !mem_rdata[pend_z_reg];
                    end
                    pend_in_reg <= nb_in;
                    pend_z_reg  <= ZW'(nb[2]);
                    b1v_reg     <= 1'b0;
                    b2v_reg     <= 1'b0;
                end
                S_SELECT:
                begin
                    if (ok_reg[idx_reg] && sel_t > 0)
                    begin
                        if (sel_e <= tol_s)
                        begin
                            if (!b1v_reg || b1err_reg > tol_s || sel_t > b1tan_reg)
                            begin
                                b1v_reg   <= 1'b1;
                                b1m_reg   <= idx_reg;
                                b1err_reg <= sel_e;
                                b1tan_reg <= sel_t;
                            end
                        end
                        else if (!b1v_reg || (b1err_reg > tol_s && sel_e < b1err_reg))
                        begin
                            b1v_reg   <= 1'b1;
                            b1m_reg   <= idx_reg;
                            b1err_reg <= sel_e;
                            b1tan_reg <= sel_t;
                        end
                    end
                    if (ok_reg[idx_reg] && (!b2v_reg || sel_e < b2err_reg))
                    begin
                        b2v_reg   <= 1'b1;
                        b2m_reg   <= idx_reg;
                        b2err_reg <= sel_e;
                    end
                end
                S_DECIDE:
                begin
                    if (boxed)
                    begin
                        live_reg <= 1'b0;
                    end
                    chosen_reg <= climb_ok ? climb_m_reg : (b1v_reg ? b1m_reg : b2m_reg);
                end
                S_APPLY:
                begin
                    energy_reg <= E_W'(energy_reg + gain_reg[chosen_reg]);
                    for (int c = 0; c < 3; c++)
                    begin
                        cross_reg[c] <= C_W'(cross_reg[c] + C_W'(dsel[c]));
                    end
                    if (!chosen_reg[0])
                    begin
                        offsq_reg <= OSQ_W'(offsq_reg + 2 * OSQ_W'(off_reg[chosen_reg[2:1]]) + 1);
                        off_reg[chosen_reg[2:1]] <= OFF_W'(off_reg[chosen_reg[2:1]] + 1);
                        tip_reg[chosen_reg[2:1]] <= COORD_W'(tip_reg[chosen_reg[2:1]] + 1);
                    end
                    else
                    begin
                        offsq_reg <= OSQ_W'(offsq_reg - 2 * OSQ_W'(off_reg[chosen_reg[2:1]]) + 1);
                        off_reg[chosen_reg[2:1]] <= OFF_W'(off_reg[chosen_reg[2:1]] - 1);
                        tip_reg[chosen_reg[2:1]] <= COORD_W'(tip_reg[chosen_reg[2:1]] - 1);
                    end
                end
                S_GUPD:
                begin
                    gain_reg[idx_reg] <= E_W'(gain_reg[idx_reg] + 2 * dot_sel_idx);
                end
                S_FIN:
                begin
                    res_stamped_reg <= 1'b1;
                    res_status_reg  <= ST_RUN;
                    if (cmd_reg == CMD_STEP)
                    begin
                        step_reg <= step_inc;
                        if (offsq_reg >= signed'(OSQ_W'(RAD2)))
                        begin
                            res_status_reg <= ST_SHELL;
                            live_reg       <= 1'b0;
                        end
                        else if (step_inc >= STEP_W'(STEP_LIMIT))
                        begin
                            res_status_reg <= ST_LIMIT;
                            live_reg       <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg       <= tip_reg[0][4:0];
            out_y_reg       <= tip_reg[1][4:0];
            out_z_reg       <= tip_reg[2][4:0];
            out_stamp_reg   <= res_stamped_reg ? 32'(tick_reg + 32'd1) : 32'd0;
            out_stamped_reg <= res_stamped_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign cmd.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.cell_x      = out_x_reg;
    assign res.cell_y      = out_y_reg;
    assign res.cell_z      = out_z_reg;
    assign res.stamp       = out_stamp_reg;
    assign res.stamped     = out_stamped_reg;
    assign res.walk_status = out_status_reg;
endmodule
`default_nettype wire
